// ===== hdl/prbs_pkg.sv =====
// Package for the planar rigid body step block: state type, fixed-point constants,
// rounding/saturation helpers and the Horner coefficient tables.
// No dependencies.
package prbs_pkg;

    localparam int MUL_W = 33;
    localparam int MOD_W = 49;

    localparam logic [30:0] ONE_Q30       = 31'd1073741824;
    localparam longint      HALF_PI_Q30   = 64'sd1686629713;
    localparam longint      TWO_PI_Q16    = 64'sd411775;
    localparam longint      PI_LOW_Q16    = 64'sd205888;
    localparam longint      MOD_BIAS      =
        TWO_PI_Q16 * (((64'sd1 <<< 47) + TWO_PI_Q16 - 64'sd1) / TWO_PI_Q16);
    // floor(2^48 / TWO_PI_Q16), quotient estimate for the heading reduction
    localparam longint      MOD_RECIP     = (64'sd1 <<< 48) / TWO_PI_Q16;
    localparam logic [16:0] UNIT_Q16      = 17'd65536;

    localparam logic [1:0]  LANE_SPIN     = 2'd3;
    localparam logic [3:0]  HK_SIN_LAST   = 4'd3;
    localparam logic [3:0]  HK_COS_LAST   = 4'd8;

    typedef enum logic [2:0] {
        CFG_INV_MASS    = 3'd0,
        CFG_INV_INERTIA = 3'd1,
        CFG_INF_MASS    = 3'd2,
        CFG_CENTER_X    = 3'd3,
        CFG_CENTER_Y    = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_AMUL, S_ASAT, S_VMUL, S_VUPD, S_PMUL, S_PUPD,
        S_MOD, S_MODQ, S_MODR, S_ANG, S_QUAD, S_SQR, S_X2, S_HMUL, S_HDIV, S_HFIX,
        S_SMUL, S_SFIN, S_CFIN, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_DONE
    } t_state;

    function automatic logic signed [65:0] f_rnd16(input logic signed [65:0] v);
        f_rnd16 = (v + 66'sd32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            f_sat32 = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            f_sat32 = 32'sh80000000;
        end else begin
            f_sat32 = v[31:0];
        end
    endfunction

    // Horner divisors: sine terms first, then cosine terms
    function automatic logic [6:0] f_hk(input logic [3:0] i);
        case (i)
            4'd0:    f_hk = 7'd72;
            4'd1:    f_hk = 7'd42;
            4'd2:    f_hk = 7'd20;
            4'd3:    f_hk = 7'd6;
            4'd4:    f_hk = 7'd90;
            4'd5:    f_hk = 7'd56;
            4'd6:    f_hk = 7'd30;
            4'd7:    f_hk = 7'd12;
            4'd8:    f_hk = 7'd2;
            default: f_hk = 7'd2;
        endcase
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] f_hr(input logic [3:0] i);
        case (i)
            4'd0:    f_hr = 32'((64'd1 << 32) / 64'd72);
            4'd1:    f_hr = 32'((64'd1 << 32) / 64'd42);
            4'd2:    f_hr = 32'((64'd1 << 32) / 64'd20);
            4'd3:    f_hr = 32'((64'd1 << 32) / 64'd6);
            4'd4:    f_hr = 32'((64'd1 << 32) / 64'd90);
            4'd5:    f_hr = 32'((64'd1 << 32) / 64'd56);
            4'd6:    f_hr = 32'((64'd1 << 32) / 64'd30);
            4'd7:    f_hr = 32'((64'd1 << 32) / 64'd12);
            4'd8:    f_hr = 32'((64'd1 << 32) / 64'd2);
            default: f_hr = 32'((64'd1 << 32) / 64'd2);
        endcase
    endfunction

endpackage

// ===== hdl/planar_rigid_body_step_top.sv =====
// Top level of the planar rigid body step: sequencer, state and config registers.
// Depends on prbs_pkg and prbs_mul.
//
// One beat in is one integration step; one beat out carries the new state, the
// heading's cosine and sine, and the transform translation. Every product goes
// through one shared 33x33 multiplier while the sequencer steps in order through
// the four lanes, the reduction of the heading modulo two pi by reciprocal
// multiplication, the angle, quadrant and square, the sine/cosine Horner steps,
// the finishing of sine and cosine and the translation, and then the output
// register is loaded. The input is ready again in the cycle after that load, so a
// new step is accepted only once the previous one is through. A finished result
// waits in the output register; the sequencer stalls in its last state only while
// the previous result is still unread.
module planar_rigid_body_step_top import prbs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // force_x, force_y, force_z, torque, delta_time, pad
    input  logic [159:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, heading, spin_rate,
    // rot_cos, rot_sin, trans_x, trans_y, pad
    output logic [343:0] o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata
);

    t_state r_state, n_state;

    logic [31:0]        r_inv_mass, r_inv_inertia;
    logic               r_inf;
    logic signed [31:0] r_cx, r_cy;

    logic signed [31:0] r_pos [3];
    logic signed [31:0] n_pos [3];
    logic signed [31:0] r_vel [4];   // lane 3 is the angular rate
    logic signed [31:0] n_vel [4];
    logic signed [18:0] r_ang, n_ang;

    logic signed [31:0] r_force [4];
    logic signed [31:0] n_force [4];
    logic [30:0]        r_dt, n_dt;
    logic [1:0]         r_idx, n_idx;
    logic signed [31:0] r_acc, n_acc;

    logic [MOD_W-1:0]   r_mod, n_mod;
    logic [18:0]        r_rem, n_rem;

    logic [1:0]         r_q, n_q;
    logic               r_neg, n_neg;
    logic [30:0]        r_u, n_u, r_x2, n_x2, r_t, n_t, r_p, n_p;
    logic [3:0]         r_k, n_k;
    logic [16:0]        r_smag, n_smag;
    logic signed [17:0] r_cos, n_cos, r_sin, n_sin;
    logic signed [49:0] r_dx, n_dx;
    logic signed [31:0] r_tx, n_tx, r_ty, n_ty;

    logic               r_ovalid, n_ovalid;
    logic [343:0]       r_odata, n_odata;

    logic                      mul_en;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] w_prod;

    prbs_mul #(.P_W(MUL_W)) u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (w_prod)
    );

    logic s_accept;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (s_accept) n_state = S_AMUL;
            S_AMUL: n_state = S_ASAT;
            S_ASAT: n_state = S_VMUL;
            S_VMUL: n_state = S_VUPD;
            S_VUPD: n_state = S_PMUL;
            S_PMUL: n_state = S_PUPD;
            S_PUPD: n_state = (r_idx == LANE_SPIN) ? S_MOD : S_AMUL;
            S_MOD:  n_state = S_MODQ;
            S_MODQ: n_state = S_MODR;
            S_MODR: n_state = S_ANG;
            S_ANG:  n_state = S_QUAD;
            S_QUAD: n_state = S_SQR;
            S_SQR:  n_state = S_X2;
            S_X2:   n_state = S_HMUL;
            S_HMUL: n_state = S_HDIV;
            S_HDIV: n_state = S_HFIX;
            S_HFIX: begin
                if (r_k == HK_SIN_LAST) begin
                    n_state = S_SMUL;
                end else if (r_k == HK_COS_LAST) begin
                    n_state = S_CFIN;
                end else begin
                    n_state = S_HMUL;
                end
            end
            S_SMUL: n_state = S_SFIN;
            S_SFIN: n_state = S_HMUL;
            S_CFIN: n_state = S_T1;
            S_T1:   n_state = S_T2;
            S_T2:   n_state = S_T3;
            S_T3:   n_state = S_T4;
            S_T4:   n_state = S_T5;
            S_T5:   n_state = S_T6;
            S_T6:   n_state = S_DONE;
            S_DONE: if (!r_ovalid || i_m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        logic signed [65:0] sum;
        logic signed [35:0] a30, v30, r30;
        logic signed [2:0]  qv;
        logic [MOD_W-1:0]   mdiff;
        logic [20:0]        r21;
        logic [30:0]        q0, dq;
        logic [37:0]        qk, hrem;
        logic [16:0]        mag;
        logic signed [17:0] ss, cc;

        n_pos = r_pos;
        n_vel = r_vel;
        n_ang = r_ang;
        n_force = r_force;
        n_dt = r_dt;
        n_idx = r_idx;
        n_acc = r_acc;
        n_mod = r_mod;
        n_rem = r_rem;
        n_q = r_q;
        n_neg = r_neg;
        n_u = r_u;
        n_x2 = r_x2;
        n_t = r_t;
        n_p = r_p;
        n_k = r_k;
        n_smag = r_smag;
        n_cos = r_cos;
        n_sin = r_sin;
        n_dx = r_dx;
        n_tx = r_tx;
        n_ty = r_ty;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_odata = r_odata;
        mul_en = 1'b0;
        mul_a = '0;
        mul_b = '0;
        sum = '0;
        a30 = '0;
        v30 = '0;
        r30 = '0;
        qv = '0;
        mdiff = '0;
        r21 = '0;
        q0 = '0;
        dq = '0;
        qk = '0;
        hrem = '0;
        mag = '0;
        ss = '0;
        cc = '0;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_force[0] = i_s_axis_tdata[31:0];
                    n_force[1] = i_s_axis_tdata[63:32];
                    n_force[2] = i_s_axis_tdata[95:64];
                    n_force[3] = i_s_axis_tdata[127:96];
                    n_dt = i_s_axis_tdata[158:128];
                    n_idx = '0;
                end
            end
            S_AMUL: begin
                mul_en = 1'b1;
                mul_a = MUL_W'(r_force[r_idx]);
                mul_b = $signed({1'b0,
                    (r_idx == LANE_SPIN) ? r_inv_inertia : r_inv_mass});
            end
            S_ASAT: begin
                n_acc = r_inf ? '0 : f_sat32(f_rnd16(w_prod));
            end
            S_VMUL: begin
                mul_en = 1'b1;
                mul_a = MUL_W'(r_acc);
                mul_b = $signed({2'b0, r_dt});
            end
            S_VUPD: begin
                n_vel[r_idx] = f_sat32(66'(r_vel[r_idx]) + f_rnd16(w_prod));
            end
            S_PMUL: begin
                mul_en = 1'b1;
                mul_a = MUL_W'(r_vel[r_idx]);
                mul_b = $signed({2'b0, r_dt});
            end
            S_PUPD: begin
                if (r_idx != LANE_SPIN) begin
                    n_pos[r_idx] = f_sat32(66'(r_pos[r_idx]) + f_rnd16(w_prod));
                    n_idx = r_idx + 2'd1;
                end else begin
                    sum = 66'(r_ang) + f_rnd16(w_prod) + 66'(PI_LOW_Q16)
                        + 66'(MOD_BIAS);
                    n_mod = sum[MOD_W-1:0];
                    n_rem = '0;
                end
            end
            S_MOD: begin
                // quotient estimate, at most two below the true quotient
                mul_en = 1'b1;
                mul_a = $signed({1'b0, r_mod[MOD_W-2:16]});
                mul_b = MUL_W'(MOD_RECIP);
            end
            S_MODQ: begin
                mul_en = 1'b1;
                mul_a = $signed({2'b0, w_prod[62:32]});
                mul_b = MUL_W'(TWO_PI_Q16);
            end
            S_MODR: begin
                mdiff = r_mod - w_prod[MOD_W-1:0];
                r21 = mdiff[20:0];
                if (r21 >= 21'(2 * TWO_PI_Q16)) r21 = r21 - 21'(2 * TWO_PI_Q16);
                if (r21 >= 21'(TWO_PI_Q16)) r21 = r21 - 21'(TWO_PI_Q16);
                n_rem = r21[18:0];
            end
            S_ANG: begin
                n_ang = 19'($signed({1'b0, r_rem}) - 20'(PI_LOW_Q16));
            end
            S_QUAD: begin
                a30 = 36'(r_ang) <<< 14;
                v30 = a30 + 36'(HALF_PI_Q30 / 2);
                if (v30 >= 36'(2 * HALF_PI_Q30)) begin
                    qv = 3'sd2;
                    r30 = a30 - 36'(2 * HALF_PI_Q30);
                end else if (v30 >= 36'(HALF_PI_Q30)) begin
                    qv = 3'sd1;
                    r30 = a30 - 36'(HALF_PI_Q30);
                end else if (v30 >= 36'sd0) begin
                    qv = 3'sd0;
                    r30 = a30;
                end else if (v30 >= -36'(HALF_PI_Q30)) begin
                    qv = -3'sd1;
                    r30 = a30 + 36'(HALF_PI_Q30);
                end else begin
                    qv = -3'sd2;
                    r30 = a30 + 36'(2 * HALF_PI_Q30);
                end
                n_q = qv[1:0];
                n_neg = r30[35];
                n_u = r30[35] ? 31'(-r30) : r30[30:0];
            end
            S_SQR: begin
                mul_en = 1'b1;
                mul_a = $signed({2'b0, r_u});
                mul_b = $signed({2'b0, r_u});
            end
            S_X2: begin
                n_x2 = w_prod[60:30];
                n_t = ONE_Q30;
                n_k = '0;
            end
            S_HMUL: begin
                mul_en = 1'b1;
                mul_a = $signed({2'b0, r_x2});
                mul_b = $signed({2'b0, r_t});
            end
            S_HDIV: begin
                n_p = w_prod[60:30];
                mul_en = 1'b1;
                mul_a = $signed({2'b0, w_prod[60:30]});
                mul_b = $signed({1'b0, f_hr(r_k)});
            end
            S_HFIX: begin
                q0 = w_prod[62:32];
                qk = 38'(q0) * 38'(f_hk(r_k));
                hrem = 38'(r_p) - qk;
                dq = (hrem >= 38'(f_hk(r_k))) ? q0 + 31'd1 : q0;
                n_t = ONE_Q30 - dq;
                n_k = r_k + 4'd1;
            end
            S_SMUL: begin
                mul_en = 1'b1;
                mul_a = $signed({2'b0, r_u});
                mul_b = $signed({2'b0, r_t});
            end
            S_SFIN: begin
                mag = 17'((32'(w_prod[60:30]) + 32'd8192) >> 14);
                n_smag = (mag > UNIT_Q16) ? UNIT_Q16 : mag;
                n_t = ONE_Q30;
            end
            S_CFIN: begin
                mag = 17'((32'(r_t) + 32'd8192) >> 14);
                if (mag > UNIT_Q16) mag = UNIT_Q16;
                cc = $signed({1'b0, mag});
                ss = r_neg ? -$signed({1'b0, r_smag}) : $signed({1'b0, r_smag});
                case (r_q)
                    2'd0: begin
                        n_cos = cc;
                        n_sin = ss;
                    end
                    2'd1: begin
                        n_cos = -ss;
                        n_sin = cc;
                    end
                    2'd2: begin
                        n_cos = -cc;
                        n_sin = -ss;
                    end
                    default: begin
                        n_cos = ss;
                        n_sin = -cc;
                    end
                endcase
            end
            S_T1: begin
                mul_en = 1'b1;
                mul_a = MUL_W'(r_cx);
                mul_b = MUL_W'(r_cos);
            end
            S_T2: begin
                n_dx = 50'(w_prod);
                mul_en = 1'b1;
                mul_a = MUL_W'(r_cy);
                mul_b = MUL_W'(r_sin);
            end
            S_T3: begin
                n_dx = r_dx - 50'(w_prod);
                mul_en = 1'b1;
                mul_a = MUL_W'(r_cx);
                mul_b = MUL_W'(r_sin);
            end
            S_T4: begin
                n_tx = f_sat32(66'(r_cx) - f_rnd16(66'(r_dx)) + 66'(r_pos[0]));
                n_dx = 50'(w_prod);
                mul_en = 1'b1;
                mul_a = MUL_W'(r_cy);
                mul_b = MUL_W'(r_cos);
            end
            S_T5: begin
                n_dx = r_dx + 50'(w_prod);
            end
            S_T6: begin
                n_ty = f_sat32(66'(r_cy) - f_rnd16(66'(r_dx)) + 66'(r_pos[1]));
            end
            S_DONE: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata = {1'b0, r_ty, r_tx, r_sin, r_cos, r_vel[3], r_ang,
                               r_vel[2], r_vel[1], r_vel[0],
                               r_pos[2], r_pos[1], r_pos[0]};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ovalid      <= 1'b0;
            r_inv_mass    <= 32'd65536;
            r_inv_inertia <= 32'd65536;
            r_inf         <= 1'b0;
            r_cx          <= '0;
            r_cy          <= '0;
            r_pos         <= '{default: '0};
            r_vel         <= '{default: '0};
            r_ang         <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_pos    <= n_pos;
            r_vel    <= n_vel;
            r_ang    <= n_ang;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_INV_MASS:    r_inv_mass    <= i_cfg_wdata;
                    CFG_INV_INERTIA: r_inv_inertia <= i_cfg_wdata;
                    CFG_INF_MASS:    r_inf         <= i_cfg_wdata[0];
                    CFG_CENTER_X:    r_cx          <= i_cfg_wdata;
                    CFG_CENTER_Y:    r_cy          <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_force <= n_force;
        r_dt    <= n_dt;
        r_idx   <= n_idx;
        r_acc   <= n_acc;
        r_mod   <= n_mod;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_neg   <= n_neg;
        r_u     <= n_u;
        r_x2    <= n_x2;
        r_t     <= n_t;
        r_p     <= n_p;
        r_k     <= n_k;
        r_smag  <= n_smag;
        r_cos   <= n_cos;
        r_sin   <= n_sin;
        r_dx    <= n_dx;
        r_tx    <= n_tx;
        r_ty    <= n_ty;
        r_odata <= n_odata;
    end

    a_start_lane0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == S_AMUL) && (r_idx == 2'd0))
        else $error("step did not start on lane 0");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ANG) |-> (r_rem < 19'(TWO_PI_Q16)))
        else $error("modulo remainder out of range");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[210:192]) >= -19'sd205888)
                         && ($signed(o_m_axis_tdata[210:192]) <= 19'sd205886))
        else $error("heading out of range");

    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[260:243]) >= -18'sd65536)
                         && ($signed(o_m_axis_tdata[260:243]) <= 18'sd65536))
        else $error("cosine out of range");

endmodule

// ===== hdl/prbs_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on prbs_pkg.
module prbs_mul import prbs_pkg::*; #(
    parameter int P_W = MUL_W
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [P_W-1:0]   i_a,
    input  logic signed [P_W-1:0]   i_b,
    output logic signed [2*P_W-1:0] o_p
);

    logic signed [2*P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_p = r_prod;

endmodule

// ===== bench/planar_rigid_body_step_top_tb.sv =====
// Testbench for planar_rigid_body_step_top: drives integration steps over a stream
// port, predicts each new state, sine/cosine and translation, and compares per field.
// Depends on prbs_pkg and the RTL of the block.
`timescale 1ns / 1ps

module planar_rigid_body_step_top_tb import prbs_pkg::*; ();

    typedef struct packed {
        logic [30:0] dt;
        logic [31:0] torque;
        logic [31:0] fz;
        logic [31:0] fy;
        logic [31:0] fx;
    } t_step;

    typedef struct {
        longint pos [3];
        longint vel [3];
        longint heading;
        longint spin;
        longint c;
        longint s;
        longint tx;
        longint ty;
    } t_body;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    // force_x, force_y, force_z, torque, delta_time, pad
    logic [159:0] s_data = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, heading, spin_rate,
    // rot_cos, rot_sin, trans_x, trans_y, pad
    logic [343:0] m_data;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [31:0]  cfg_wdata = '0;

    planar_rigid_body_step_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state and configuration
    longint inv_mass = 65536, inv_inertia = 65536, cx = 0, cy = 0;
    bit     frozen = 1'b0;
    longint body_pos [3], body_vel [3], body_ang = 0, body_spin = 0;

    t_step  pending_steps [$];
    t_body  expected_bodies [$];
    int     errors = 0;
    int     results_seen = 0;
    int     send_idle = 37, recv_idle = 68;
    longint cycles = 0;

    function automatic longint rnd16(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void heading_trig(longint a16, output longint co, output longint si);
        longint a30, q, r, num, s, c;
        longint unsigned u, x2, t;
        longint unsigned sk [4] = '{72, 42, 20, 6};
        longint unsigned ck [5] = '{90, 56, 30, 12, 2};
        bit neg;
        a30 = a16 * 16384;
        num = a30 + HALF_PI_Q30 / 2;
        q = (num >= 0) ? num / HALF_PI_Q30 : -((-num + HALF_PI_Q30 - 1) / HALF_PI_Q30);
        r = a30 - q * HALF_PI_Q30;
        neg = r < 0;
        u = neg ? -r : r;
        x2 = (u * u) >> 30;
        t = 64'd1073741824;
        for (int i = 0; i < 4; i++) t = 64'd1073741824 - ((x2 * t) >> 30) / sk[i];
        s = longint'((((u * t) >> 30) + 8192) >> 14);
        t = 64'd1073741824;
        for (int i = 0; i < 5; i++) t = 64'd1073741824 - ((x2 * t) >> 30) / ck[i];
        c = longint'((t + 8192) >> 14);
        if (s > 65536) s = 65536;
        if (c > 65536) c = 65536;
        if (neg) s = -s;
        case (((q % 4) + 4) % 4)
            0: begin co = c;  si = s;  end
            1: begin co = -s; si = c;  end
            2: begin co = -c; si = -s; end
            default: begin co = s; si = -c; end
        endcase
    endfunction

    function automatic t_body integrate_step(t_step st);
        t_body  b;
        longint dt, acc, alpha, h;
        longint frc [3];
        dt = longint'(st.dt);
        frc[0] = longint'(signed'(st.fx));
        frc[1] = longint'(signed'(st.fy));
        frc[2] = longint'(signed'(st.fz));
        for (int i = 0; i < 3; i++) begin
            acc = frozen ? 0 : clamp32(rnd16(frc[i] * inv_mass));
            body_vel[i] = clamp32(body_vel[i] + rnd16(acc * dt));
            body_pos[i] = clamp32(body_pos[i] + rnd16(body_vel[i] * dt));
            b.pos[i] = body_pos[i];
            b.vel[i] = body_vel[i];
        end
        alpha = frozen ? 0 : clamp32(rnd16(longint'(signed'(st.torque)) * inv_inertia));
        body_spin = clamp32(body_spin + rnd16(alpha * dt));
        h = (body_ang + rnd16(body_spin * dt) + PI_LOW_Q16) % TWO_PI_Q16;
        if (h < 0) h += TWO_PI_Q16;
        body_ang = h - PI_LOW_Q16;
        b.heading = body_ang;
        b.spin = body_spin;
        heading_trig(body_ang, b.c, b.s);
        b.tx = clamp32(cx - rnd16(cx * b.c - cy * b.s) + body_pos[0]);
        b.ty = clamp32(cy - rnd16(cx * b.s + cy * b.c) + body_pos[1]);
        return b;
    endfunction

    task automatic compare_field(string name, longint expv, logic [31:0] got, int w);
        logic [31:0] e;
        e = 32'(expv);
        if (w < 32) e = e & ((32'd1 << w) - 1);
        if (e !== got) begin
            $error("%s expected %h got %h", name, e, got);
            errors++;
        end
    endtask

    // accept seen at the last rising edge
    logic s_ready_q = 1'b0;
    always @(posedge i_clk) begin
        s_ready_q <= s_valid && s_ready;
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_valid || s_ready_q) begin
                if (pending_steps.size() > 0 && $urandom_range(99) >= send_idle) begin
                    s_data <= {1'b0, pending_steps.pop_front()};
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && s_valid && s_ready)
            expected_bodies.push_back(integrate_step(t_step'(s_data[158:0])));
        if (i_rst_n && m_valid && m_ready) begin
            results_seen++;
            if (expected_bodies.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                t_body b;
                b = expected_bodies.pop_front();
                compare_field("pos_x", b.pos[0], m_data[31:0], 32);
                compare_field("pos_y", b.pos[1], m_data[63:32], 32);
                compare_field("pos_z", b.pos[2], m_data[95:64], 32);
                compare_field("vel_x", b.vel[0], m_data[127:96], 32);
                compare_field("vel_y", b.vel[1], m_data[159:128], 32);
                compare_field("vel_z", b.vel[2], m_data[191:160], 32);
                compare_field("heading", b.heading, 32'(m_data[210:192]), 19);
                compare_field("spin_rate", b.spin, m_data[242:211], 32);
                compare_field("rot_cos", b.c, 32'(m_data[260:243]), 18);
                compare_field("rot_sin", b.s, 32'(m_data[278:261]), 18);
                compare_field("trans_x", b.tx, m_data[310:279], 32);
                compare_field("trans_y", b.ty, m_data[342:311], 32);
            end
        end
        if (cycles > 64'd3000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'(signed'($urandom_range(200000)) - 100000);
            3: return 32'(signed'($urandom_range(8000000)) - 4000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_dt();
        case ($urandom_range(5))
            0: return 31'h7fffffff;
            1: return 31'd0;
            2: return 31'($urandom);
            default: return 31'($urandom_range(70000));
        endcase
    endfunction

    task automatic drain();
        while (pending_steps.size() > 0 || s_valid || expected_bodies.size() > 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_INV_MASS:    inv_mass = longint'(val);
            CFG_INV_INERTIA: inv_inertia = longint'(val);
            CFG_INF_MASS:    frozen = val[0];
            CFG_CENTER_X:    cx = longint'(signed'(val));
            CFG_CENTER_Y:    cy = longint'(signed'(val));
            default: ;
        endcase
    endtask

    task automatic queue_random(int n);
        t_step st;
        for (int i = 0; i < n; i++) begin
            st.fx = rand_word();
            st.fy = rand_word();
            st.fz = rand_word();
            st.torque = rand_word();
            st.dt = rand_dt();
            pending_steps.push_back(st);
        end
    endtask

    initial begin
        t_step st;
        for (int i = 0; i < 3; i++) begin
            body_pos[i] = 0;
            body_vel[i] = 0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero, extremes, small spins crossing the angle wrap
        st = '{dt: 31'd65536, torque: 32'd0, fz: 32'd0, fy: 32'd0, fx: 32'd0};
        pending_steps.push_back(st);
        st = '{dt: 31'h7fffffff, torque: 32'h7fffffff, fz: 32'h80000000,
               fy: 32'h7fffffff, fx: 32'h80000000};
        pending_steps.push_back(st);
        pending_steps.push_back(st);
        st = '{dt: 31'h7fffffff, torque: 32'h80000000, fz: 32'h7fffffff,
               fy: 32'h80000000, fx: 32'h7fffffff};
        pending_steps.push_back(st);
        st = '{dt: 31'd0, torque: 32'hffffffff, fz: 32'hffffffff,
               fy: 32'hffffffff, fx: 32'hffffffff};
        pending_steps.push_back(st);
        for (int i = 0; i < 10; i++) begin
            st = '{dt: 31'd16384, torque: 32'd30000, fz: 32'd1,
                   fy: 32'hffff0000, fx: 32'd65536};
            pending_steps.push_back(st);
        end
        drain();

        write_reg(CFG_INV_MASS, 32'd0);
        write_reg(CFG_INV_INERTIA, 32'd0);
        write_reg(CFG_CENTER_X, 32'h7fffffff);
        write_reg(CFG_CENTER_Y, 32'h80000000);
        queue_random(5);
        drain();

        write_reg(CFG_INV_MASS, 32'hffffffff);
        write_reg(CFG_INV_INERTIA, 32'hffffffff);
        write_reg(CFG_INF_MASS, 32'd1);
        queue_random(5);
        drain();
        write_reg(CFG_INF_MASS, 32'd0);
        queue_random(300);
        drain();

        send_idle = 68;
        recv_idle = 37;
        write_reg(CFG_INV_MASS, 32'd65536);
        write_reg(CFG_INV_INERTIA, 32'd32768);
        write_reg(CFG_CENTER_X, 32'h80000000);
        write_reg(CFG_CENTER_Y, 32'h7fffffff);
        queue_random(400);
        drain();

        send_idle = 0;
        recv_idle = 0;
        write_reg(CFG_INV_MASS, $urandom);
        write_reg(CFG_INV_INERTIA, $urandom);
        write_reg(CFG_CENTER_X, $urandom);
        write_reg(CFG_CENTER_Y, $urandom);
        queue_random(390);
        drain();

        $display("Ran %0d integration steps across six register settings,", results_seen);
        $display("covering saturation, zero and full inverse mass, frozen body and stalls.");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
